/* design/sdec_pkg.sv */
// shared constants and state types for the signed decimal text converter
package sdec_pkg;

    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_MINUS = 8'd45;

    // binary bits folded into the bcd register per converter cycle
    localparam int STEP_BITS = 4;

    typedef enum logic [1:0] {
        CONV_IDLE,
        CONV_RUN,
        CONV_DONE
    } conv_state_t;

    typedef enum logic [1:0] {
        EMIT_IDLE,
        EMIT_SIGN,
        EMIT_DIGITS
    } emit_state_t;

endpackage

/* design/sdec_front.sv */
// front stage: takes a value, splits it into sign flag and magnitude
module sdec_front
    import sdec_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [VALUE_WIDTH-1:0] value,
    output logic                   q_valid,
    input  logic                   q_stall,
    output logic                   q_neg,
    output logic [VALUE_WIDTH-1:0] q_mag
);

    logic                   valid_reg;
    logic                   neg_reg;
    logic [VALUE_WIDTH-1:0] mag_reg;
    logic [VALUE_WIDTH-1:0] mag_next;

    assign in_stall = valid_reg && q_stall;
    assign q_valid  = valid_reg;
    assign q_neg    = neg_reg;
    assign q_mag    = mag_reg;

    // unsigned negation also gives the exact magnitude of the most negative value
    assign mag_next = value[VALUE_WIDTH-1] ? (~value + VALUE_WIDTH'(1)) : value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            neg_reg <= value[VALUE_WIDTH-1];
            mag_reg <= mag_next;
        end
    end

endmodule

/* design/sdec_queue.sv */
// two-entry queue between the front stage and the converter
module sdec_queue
    import sdec_pkg::*;
#(
    parameter int WIDTH = 33
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_stall,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_stall,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             push;
    logic             pop;

    assign push_stall = (count_reg == 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && !push_stall;
    assign pop        = pop_valid && !pop_stall;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("queue count missed a transfer");

endmodule

/* design/sdec_conv.sv */
// binary to bcd converter, shift-and-add-three over several bits per cycle
module sdec_conv
    import sdec_pkg::*;
#(
    parameter int VALUE_WIDTH = 32,
    parameter int DIGITS      = 10
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   in_neg,
    input  logic [VALUE_WIDTH-1:0] in_mag,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   out_neg,
    output logic [DIGITS*4-1:0]    out_bcd
);

    localparam int MAG_W = ((VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
    localparam int STEPS = MAG_W / STEP_BITS;
    localparam int CNT_W = $clog2(STEPS);
    localparam int BCD_W = DIGITS * 4;

    conv_state_t        state_reg;
    conv_state_t        state_next;
    logic [MAG_W-1:0]   bin_reg;
    logic [MAG_W-1:0]   bin_next;
    logic [BCD_W-1:0]   bcd_reg;
    logic [BCD_W-1:0]   bcd_next;
    logic               neg_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [MAG_W-1:0]   bin_step;
    logic [BCD_W-1:0]   bcd_step;
    logic               load;

    assign out_valid = (state_reg == CONV_DONE);
    assign out_neg   = neg_reg;
    assign out_bcd   = bcd_reg;

    // STEP_BITS rounds of add-three then shift
    always_comb
    begin
        bcd_step = bcd_reg;
        bin_step = bin_reg;
        for (int s = 0; s < STEP_BITS; s++)
        begin
            for (int d = 0; d < DIGITS; d++)
            begin
                if (bcd_step[d*4 +: 4] >= 4'd5)
                begin
                    bcd_step[d*4 +: 4] = bcd_step[d*4 +: 4] + 4'd3;
                end
            end
            bcd_step = {bcd_step[BCD_W-2:0], bin_step[MAG_W-1]};
            bin_step = {bin_step[MAG_W-2:0], 1'b0};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        load       = 1'b0;
        in_stall   = 1'b1;
        case (state_reg)
            CONV_IDLE:
            begin
                in_stall = 1'b0;
                load     = in_valid;
            end
            CONV_RUN:
            begin
                bin_next = bin_step;
                bcd_next = bcd_step;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = CONV_DONE;
                end
            end
            CONV_DONE:
            begin
                if (!out_stall)
                begin
                    in_stall   = 1'b0;
                    load       = in_valid;
                    state_next = CONV_IDLE;
                end
            end
            default:
            begin
                state_next = CONV_IDLE;
            end
        endcase
        if (load)
        begin
            state_next = CONV_RUN;
            bin_next   = MAG_W'(in_mag);
            bcd_next   = '0;
            cnt_next   = CNT_W'(STEPS - 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CONV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        if (load)
        begin
            neg_reg <= in_neg;
        end
    end

    a_cnt_down: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CONV_RUN && cnt_reg != '0)
        |=> (state_reg == CONV_RUN && cnt_reg == $past(cnt_reg) - CNT_W'(1)))
        else $error("converter step count skipped");

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CONV_RUN && cnt_reg == '0) |=> (state_reg == CONV_DONE))
        else $error("converter did not finish after last step");

    a_bin_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CONV_DONE) |-> (bin_reg == '0))
        else $error("converter finished with binary bits left");

endmodule

/* design/sdec_emit.sv */
// character sequencer: minus sign for a negative number, then digits from the most significant nonzero one
module sdec_emit
    import sdec_pkg::*;
#(
    parameter int DIGITS = 10
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                in_neg,
    input  logic [DIGITS*4-1:0] in_bcd,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          character,
    output logic                last
);

    localparam int IDX_W = $clog2(DIGITS);

    emit_state_t      state_reg;
    emit_state_t      state_next;
    logic [3:0]       digit_reg [DIGITS];
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [IDX_W-1:0] top_idx;
    logic             ovalid_reg;
    logic             ovalid_next;
    logic [7:0]       char_reg;
    logic [7:0]       char_next;
    logic             last_reg;
    logic             last_next;
    logic             out_free;
    logic             produce;
    logic             load;

    assign out_valid = ovalid_reg;
    assign character = char_reg;
    assign last      = last_reg;
    assign out_free  = !ovalid_reg || !out_stall;

    // most significant nonzero digit, units digit when the value is zero
    always_comb
    begin
        top_idx = '0;
        for (int d = 0; d < DIGITS; d++)
        begin
            if (in_bcd[d*4 +: 4] != 4'd0)
            begin
                top_idx = IDX_W'(d);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        produce    = 1'b0;
        char_next  = char_reg;
        last_next  = last_reg;
        in_stall   = 1'b1;
        case (state_reg)
            EMIT_IDLE:
            begin
                in_stall = 1'b0;
            end
            EMIT_SIGN:
            begin
                if (out_free)
                begin
                    produce    = 1'b1;
                    char_next  = ASCII_MINUS;
                    last_next  = 1'b0;
                    state_next = EMIT_DIGITS;
                end
            end
            EMIT_DIGITS:
            begin
                if (out_free)
                begin
                    produce   = 1'b1;
                    char_next = ASCII_ZERO + {4'd0, digit_reg[idx_reg]};
                    last_next = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        in_stall   = 1'b0;
                        state_next = EMIT_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = EMIT_IDLE;
            end
        endcase
        load = in_valid && !in_stall;
        if (load)
        begin
            idx_next   = top_idx;
            state_next = in_neg ? EMIT_SIGN : EMIT_DIGITS;
        end
        ovalid_next = produce || (ovalid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= EMIT_IDLE;
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
        if (load)
        begin
            for (int d = 0; d < DIGITS; d++)
            begin
                digit_reg[d] <= in_bcd[d*4 +: 4];
            end
        end
    end

    a_sign_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == EMIT_SIGN && out_free)
        |=> (ovalid_reg && char_reg == ASCII_MINUS && !last_reg))
        else $error("sign character not issued as expected");

    a_last_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && last_reg) |-> (char_reg != ASCII_MINUS))
        else $error("final character is not a digit");

    a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_stall && state_reg != EMIT_IDLE)
        |-> (state_reg == EMIT_DIGITS && idx_reg == '0 && out_free))
        else $error("sequencer took a number while still busy");

endmodule

/* design/signed_int_to_decimal_ascii.sv */
// top level: signed integer to decimal ascii text, one character per output transfer
// the rate of numbers is bounded by the bcd converter loop and by the output, which gives
//   one character per cycle while out_stall is low
// reset: rst_n is asynchronous active low, clears all control state and empties the queue;
//   digit and payload registers are not reset and are written before use
module signed_int_to_decimal_ascii
    import sdec_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [VALUE_WIDTH-1:0] value,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [7:0]             character,
    output logic                   last
);

    // digits in the largest magnitude 2^(VALUE_WIDTH-1): floor((w-1)*log10(2)) + 1
    localparam int DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
    localparam int Q_W    = VALUE_WIDTH + 1;

    // front stage to queue
    logic                   fq_valid;
    logic                   fq_stall;
    logic                   fq_neg;
    logic [VALUE_WIDTH-1:0] fq_mag;

    // queue to converter
    logic                   qc_valid;
    logic                   qc_stall;
    logic [Q_W-1:0]         qc_data;

    // converter to character sequencer
    logic                   ce_valid;
    logic                   ce_stall;
    logic                   ce_neg;
    logic [DIGITS*4-1:0]    ce_bcd;

    // front: registers the value as a sign flag and an unsigned magnitude
    sdec_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .value    (value),
        .q_valid  (fq_valid),
        .q_stall  (fq_stall),
        .q_neg    (fq_neg),
        .q_mag    (fq_mag)
    );

    // short queue so the front keeps taking numbers while the back is busy
    sdec_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_stall (fq_stall),
        .push_data  ({fq_neg, fq_mag}),
        .pop_valid  (qc_valid),
        .pop_stall  (qc_stall),
        .pop_data   (qc_data)
    );

    // back, part one: magnitude into packed bcd digits
    sdec_conv #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .DIGITS      (DIGITS)
    ) u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (qc_valid),
        .in_stall  (qc_stall),
        .in_neg    (qc_data[Q_W-1]),
        .in_mag    (qc_data[VALUE_WIDTH-1:0]),
        .out_valid (ce_valid),
        .out_stall (ce_stall),
        .out_neg   (ce_neg),
        .out_bcd   (ce_bcd)
    );

    // back, part two: sign and digits out, with a registered output stage
    sdec_emit #(
        .DIGITS (DIGITS)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ce_valid),
        .in_stall  (ce_stall),
        .in_neg    (ce_neg),
        .in_bcd    (ce_bcd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .character (character),
        .last      (last)
    );

endmodule

/* bench/decimal_text_sb_pkg.sv */
// scoreboard class for the signed decimal text converter bench
package decimal_text_sb_pkg;

    import sdec_pkg::*;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } text_char_t;

    class decimal_text_scoreboard;

        text_char_t pending_chars[$];
        int         mismatches;
        int         chars_seen;

        function new();
            mismatches = 0;
            chars_seen = 0;
        endfunction

        // work out the text of one accepted number and queue its characters
        function void note_number(logic [31:0] number);
            logic [31:0] magnitude;
            logic [3:0]  digits[10];
            int          n_digits;
            text_char_t  ch;

            magnitude = number[31] ? (~number + 32'd1) : number;
            n_digits  = 0;
            do
            begin
                digits[n_digits] = 4'(magnitude % 32'd10);
                n_digits++;
                magnitude = magnitude / 32'd10;
            end
            while (magnitude != 32'd0);

            if (number[31])
            begin
                ch.character = ASCII_MINUS;
                ch.last      = 1'b0;
                pending_chars.push_back(ch);
            end
            for (int k = n_digits - 1; k >= 0; k--)
            begin
                ch.character = ASCII_ZERO + 8'(digits[k]);
                ch.last      = (k == 0);
                pending_chars.push_back(ch);
            end
        endfunction

        // compare one output transfer with the oldest queued character
        function void check_char(logic [7:0] character, logic last);
            text_char_t want;

            chars_seen++;
            if (pending_chars.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected character %0d last %0b at output transfer %0d",
                             character, last, chars_seen);
                return;
            end
            want = pending_chars.pop_front();
            if (want.character !== character || want.last !== last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("output transfer %0d: expected char %0d last %0b, got char %0d last %0b",
                             chars_seen, want.character, want.last, character, last);
            end
        endfunction

        function int outstanding();
            return pending_chars.size();
        endfunction

        function bit failed();
            return (mismatches != 0) || (pending_chars.size() != 0);
        endfunction

    endclass

endpackage

/* bench/tb_signed_int_to_decimal_ascii.sv */
// top level bench: random and directed numbers through the decimal text converter
module tb_signed_int_to_decimal_ascii;

    timeunit 1ns;
    timeprecision 1ps;

    import sdec_pkg::*;
    import decimal_text_sb_pkg::*;

    // idle cycles with no transfer on either side before the run is abandoned
    localparam int WATCHDOG_LIMIT = 3000;
    // settle time after the last expected character, well above the block latency
    localparam int TAIL_CYCLES    = 40;
    localparam int RANDOM_ITEMS   = 480;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [31:0] value     = 32'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  character;
    logic        last;

    decimal_text_scoreboard sb = new();

    // sender burst bookkeeping
    int burst_left = 0;

    // receiver stall pattern
    stall_mode_t stall_mode       = STALL_NONE;
    int          stall_phase_left = 0;
    int          stall_tick       = 0;

    int idle_cycles = 0;

    signed_int_to_decimal_ascii #(
        .VALUE_WIDTH(32)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .character (character),
        .last      (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // present one number and hold it until the block takes the transfer
    task automatic send_value(input logic [31:0] number);
        in_valid <= 1'b1;
        value    <= number;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_number(number);
    endtask

    // wrap each number in the burst and gap pattern of the sender
    task automatic push_number(input logic [31:0] number);
        int gap;

        if (burst_left == 0)
        begin
            // now and then a long burst with no gap at all
            if ($urandom_range(0, 5) == 0)
            begin
                gap        = 0;
                burst_left = $urandom_range(20, 50);
            end
            else
            begin
                gap        = $urandom_range(0, 15);
                burst_left = $urandom_range(1, 12);
            end
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        send_value(number);
    endtask

    // hold the sender off until every queued character has come out
    task automatic drain_text();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pow10(input int k);
        logic [31:0] p;

        p = 32'd1;
        for (int i = 0; i < k; i++)
            p = p * 32'd10;
        return p;
    endfunction

    function automatic logic [31:0] negate(input logic [31:0] mag);
        return ~mag + 32'd1;
    endfunction

    // mix of full-range values, edges, powers of ten and uniform digit lengths
    function automatic logic [31:0] random_number();
        logic [31:0] mag;
        logic [31:0] lo;
        logic [31:0] hi;
        int          d;

        case ($urandom_range(0, 9))
            0: return $urandom;
            1:
            begin
                case ($urandom_range(0, 6))
                    0: return 32'h0000_0000;
                    1: return 32'h0000_0001;
                    2: return 32'hFFFF_FFFF;
                    3: return 32'h7FFF_FFFF;
                    4: return 32'h8000_0000;
                    5: return 32'h8000_0001;
                    default: return 32'h7FFF_FFFE;
                endcase
            end
            2:
            begin
                mag = pow10($urandom_range(0, 9));
                case ($urandom_range(0, 2))
                    0: mag = mag - 32'd1;
                    1: mag = mag + 32'd1;
                    default: ;
                endcase
                return $urandom_range(0, 1) ? negate(mag) : mag;
            end
            default:
            begin
                d   = $urandom_range(1, 10);
                lo  = (d == 1) ? 32'd0 : pow10(d - 1);
                hi  = (d == 10) ? 32'h7FFF_FFFF : pow10(d) - 32'd1;
                mag = $urandom_range(hi, lo);
                return $urandom_range(0, 1) ? negate(mag) : mag;
            end
        endcase
    endfunction

    // receiver: check each output transfer, then pick the next stall value
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_char(character, last);

        if (stall_phase_left == 0)
        begin
            stall_mode       <= stall_mode_t'($urandom_range(0, 3));
            stall_phase_left <= $urandom_range(20, 200);
        end
        else
        begin
            stall_phase_left <= stall_phase_left - 1;
        end
        stall_tick <= stall_tick + 1;

        case (stall_mode)
            STALL_NONE:     out_stall <= 1'b0;
            STALL_LIGHT:    out_stall <= ($urandom_range(0, 9) < 3);
            STALL_HEAVY:    out_stall <= ($urandom_range(0, 9) < 7);
            STALL_PERIODIC: out_stall <= (stall_tick % 5 == 0);
            default:        out_stall <= 1'b0;
        endcase
    end

    // watchdog: too long with no transfer anywhere means the block has hung
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        // reset held low at the start, released on a rising edge
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part: zero, single digits, decade edges, both extremes
        push_number(32'd0);
        push_number(32'd1);
        push_number(32'hFFFF_FFFF);          // minus one
        push_number(32'd9);
        push_number(32'd10);
        push_number(negate(32'd10));
        push_number(32'd99);
        push_number(32'd100);
        push_number(32'h7FFF_FFFF);          // most positive
        push_number(32'h8000_0000);          // most negative, no special path
        push_number(32'h8000_0001);
        push_number(32'd1000000000);
        push_number(32'd999999999);
        push_number(negate(32'd999999999));
        push_number(32'd123456789);
        push_number(32'h5555_5555);
        push_number(32'hAAAA_AAAA);
        push_number(32'h7FFF_FFFE);
        push_number(32'd1000000);
        push_number(negate(32'd1000000000));
        push_number(32'd0);
        push_number(32'd0);                  // back-to-back zeros

        // let the queue run dry once before the random part
        drain_text();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            push_number(random_number());
            if (i % 120 == 119)
                drain_text();
        end

        drain_text();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.failed())
            $display("TB_ERROR");
        else
            $display("TB_OK");
        $finish;
    end

endmodule
